@@ design/dse_pkg.sv @@
// Shared types and constants of the diagonal Sobel edge filter.
// No dependencies; used by the top level by scoped names.
package dse_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
    } src_item_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_last;
    } dst_item_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int MAX_HEIGHT     = 4096;
    localparam int OUT_ROW_W      = 12;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Signed kernel sums stay within +-1020, divisor magnitudes within 4.
    localparam int ACC_W     = 12;
    localparam int WSUM_W    = 4;
    localparam int DIV_W     = 11;
    localparam int DIVISOR_W = 3;
    localparam logic [3:0] DIV_STEPS = 4'd11;

    // Weight at offset (dy,dx) is K[dx+1][dy+1].
    localparam logic signed [2:0] K45 [3][3] = '{
        '{ 3'sd0,  3'sd1,  3'sd2},
        '{ 3'sd1,  3'sd0, -3'sd1},
        '{-3'sd2, -3'sd1,  3'sd0}
    };
    localparam logic signed [2:0] K135 [3][3] = '{
        '{ 3'sd2,  3'sd1,  3'sd0},
        '{-3'sd1,  3'sd0,  3'sd1},
        '{ 3'sd0, -3'sd1, -3'sd2}
    };

endpackage

@@ design/diagonal_sobel_edge_filter.sv @@
// Top level of the diagonal Sobel edge filter: sequencer, line store and divider.
// Depends on dse_pkg and dse_ram.
//
// Usage: pixels of a frame enter in raster order on the src channel (op = pixel);
// after the last pixel, flush items (op = flush) drain the remaining results. Each
// result on the dst channel carries the combined diagonal edge magnitude, saturated
// at 255, and frame_last marks the final pixel of the frame.
// A transfer takes place when valid is high and stall is low.
// An item that gives a result is stored if it is a pixel, then passes through nine
// line-store reads (one per window tap on the single read port), the collection of
// the last, a set-up step, eleven steps of the bit-serial divider and the load of
// the output register; the src channel stalls until the sequencer is idle again.
// The first result appears once the pixel one row and one column beyond it has
// arrived. The output register holds a waiting result while the next item is taken;
// a stalled receiver only holds the sequencer when a new result is ready to load.
// Reset clears the counters and the output valid flag and restores the sizes to
// 640 by 480; the line store needs no clearing. A size write taken while idle
// abandons the frame in progress; one made while src_stall is high is ignored.
module diagonal_sobel_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [dse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              src_valid,
    output logic                              src_stall,
    input  dse_pkg::src_item_t                src_data,
    output logic                              dst_valid,
    input  logic                              dst_stall,
    output dse_pkg::dst_item_t                dst_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = CW + 2;
    localparam int LW = CW + 14;
    localparam int RW = dse_pkg::FRAME_HEIGHT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_LAST = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [dse_pkg::FRAME_WIDTH_W-1:0]  fw_reg, fw_next;
    logic [dse_pkg::FRAME_HEIGHT_W-1:0] fh_reg, fh_next;
    logic [CW-1:0]                      in_col_reg, in_col_next;
    logic [RW-1:0]                      in_row_reg, in_row_next;
    logic [CW-1:0]                      out_col_reg, out_col_next;
    logic [dse_pkg::OUT_ROW_W-1:0]      out_row_reg, out_row_next;
    logic [LW-1:0]                      lead_reg, lead_next;

    logic [1:0] ty_reg, ty_next, tx_reg, tx_next;
    logic       tap_valid_reg, tap_valid_next;
    logic       tap_in_reg, tap_in_next;
    logic signed [2:0] w45_reg, w45_next, w135_reg, w135_next;

    logic signed [dse_pkg::ACC_W-1:0]  acc45_reg, acc45_next, acc135_reg, acc135_next;
    logic signed [dse_pkg::WSUM_W-1:0] ws45_reg, ws45_next, ws135_reg, ws135_next;

    logic [dse_pkg::DIV_W-1:0]     dq45_reg, dq45_next, dq135_reg, dq135_next;
    logic [dse_pkg::DIVISOR_W-1:0] rm45_reg, rm45_next, rm135_reg, rm135_next;
    logic [dse_pkg::DIVISOR_W-1:0] dv45_reg, dv45_next, dv135_reg, dv135_next;
    logic [3:0]                    div_cnt_reg, div_cnt_next;

    logic                 dst_valid_reg, dst_valid_next;
    dse_pkg::dst_item_t   dst_data_reg, dst_data_next;

    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    rdata;
    logic          row_ok, col_ok, out_free, is_last;
    logic [1:0]    rd_slot;
    logic [CW-1:0] rd_col;
    logic signed [dse_pkg::ACC_W-1:0] abs45, abs135;
    logic [dse_pkg::DIV_W:0]          qsum;
    logic [dse_pkg::DIV_W-1:0]        half;
    logic [dse_pkg::DIVISOR_W:0]      t45, t135;

    always_comb
    begin
        if (fw_reg == '0)
            eff_w = WW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(fw_reg);
        if (fh_reg == '0)
            eff_h = RW'(1);
        else if (32'(fh_reg) > dse_pkg::MAX_HEIGHT)
            eff_h = RW'(dse_pkg::MAX_HEIGHT);
        else
            eff_h = fh_reg;
    end

    // Window tap addressing and frame-edge tests for the tap being issued.
    always_comb
    begin
        unique case (ty_reg)
            2'd0:    row_ok = (out_row_reg != '0);
            2'd2:    row_ok = ((RW'(out_row_reg) + RW'(1)) < eff_h);
            default: row_ok = 1'b1;
        endcase
        unique case (tx_reg)
            2'd0:    col_ok = (out_col_reg != '0);
            2'd2:    col_ok = (((WW + 1)'(out_col_reg) + (WW + 1)'(1)) < (WW + 1)'(eff_w));
            default: col_ok = 1'b1;
        endcase
        rd_slot = out_row_reg[1:0] + ty_reg - 2'd1;
        rd_col  = out_col_reg + CW'(tx_reg) - CW'(1);
        raddr   = {rd_slot, rd_col};
    end

    assign is_last  = (RW'(out_row_reg) == eff_h - RW'(1))
                   && ((WW + 1)'(out_col_reg) == (WW + 1)'(eff_w) - (WW + 1)'(1));
    assign out_free = !dst_valid_reg || !dst_stall;
    assign src_stall = (state_reg != S_IDLE);
    assign we    = (state_reg == S_IDLE) && src_valid
                && (src_data.op == dse_pkg::OP_PIXEL) && (in_row_reg < eff_h);
    assign waddr = {in_row_reg[1:0], in_col_reg};

    assign abs45  = acc45_reg[dse_pkg::ACC_W-1] ? -acc45_reg : acc45_reg;
    assign abs135 = acc135_reg[dse_pkg::ACC_W-1] ? -acc135_reg : acc135_reg;
    assign t45    = {rm45_reg, dq45_reg[dse_pkg::DIV_W-1]};
    assign t135   = {rm135_reg, dq135_reg[dse_pkg::DIV_W-1]};
    assign qsum   = {1'b0, dq45_reg} + {1'b0, dq135_reg};
    assign half   = qsum[dse_pkg::DIV_W:1];

    dse_ram #(
        .WIDTH (8),
        .DEPTH (1 << AW)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (src_data.pixel),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        lead_next      = lead_reg;
        ty_next        = ty_reg;
        tx_next        = tx_reg;
        tap_valid_next = 1'b0;
        tap_in_next    = tap_in_reg;
        w45_next       = w45_reg;
        w135_next      = w135_reg;
        acc45_next     = acc45_reg;
        acc135_next    = acc135_reg;
        ws45_next      = ws45_reg;
        ws135_next     = ws135_reg;
        dq45_next      = dq45_reg;
        dq135_next     = dq135_reg;
        rm45_next      = rm45_reg;
        rm135_next     = rm135_reg;
        dv45_next      = dv45_reg;
        dv135_next     = dv135_reg;
        div_cnt_next   = div_cnt_reg;
        dst_valid_next = dst_valid_reg && dst_stall;
        dst_data_next  = dst_data_reg;

        // Collect the tap read in the previous cycle.
        if (tap_valid_reg && tap_in_reg)
        begin
            acc45_next  = acc45_reg
                        + dse_pkg::ACC_W'($signed({5'b0, rdata}) * w45_reg);
            acc135_next = acc135_reg
                        + dse_pkg::ACC_W'($signed({5'b0, rdata}) * w135_reg);
            ws45_next   = ws45_reg + dse_pkg::WSUM_W'(w45_reg);
            ws135_next  = ws135_reg + dse_pkg::WSUM_W'(w135_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_write)
                begin
                    unique case (cfg_index)
                        dse_pkg::CFG_FRAME_WIDTH:
                            fw_next = cfg_data[dse_pkg::FRAME_WIDTH_W-1:0];
                        dse_pkg::CFG_FRAME_HEIGHT:
                            fh_next = cfg_data;
                        default: ;
                    endcase
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    lead_next    = '0;
                end
                else if (src_valid)
                begin
                    ty_next     = 2'd0;
                    tx_next     = 2'd0;
                    acc45_next  = '0;
                    acc135_next = '0;
                    ws45_next   = '0;
                    ws135_next  = '0;
                    if (we)
                    begin
                        if (((WW + 1)'(in_col_reg) + (WW + 1)'(1)) >= (WW + 1)'(eff_w))
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + RW'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + CW'(1);
                        end
                        lead_next = lead_reg + LW'(1);
                        if ((lead_reg + LW'(1)) >= (LW'(eff_w) + LW'(2)))
                            state_next = S_READ;
                    end
                    else if (in_row_reg >= eff_h)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                tap_valid_next = 1'b1;
                tap_in_next    = row_ok && col_ok;
                w45_next       = dse_pkg::K45[tx_reg][ty_reg];
                w135_next      = dse_pkg::K135[tx_reg][ty_reg];
                if (tx_reg == 2'd2)
                begin
                    tx_next = 2'd0;
                    if (ty_reg == 2'd2)
                        state_next = S_LAST;
                    else
                        ty_next = ty_reg + 2'd1;
                end
                else
                begin
                    tx_next = tx_reg + 2'd1;
                end
            end
            S_LAST:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                // Quotient magnitudes are all that the result needs.
                dq45_next  = abs45[dse_pkg::DIV_W-1:0];
                dq135_next = abs135[dse_pkg::DIV_W-1:0];
                rm45_next  = '0;
                rm135_next = '0;
                if (ws45_reg == '0)
                    dv45_next = dse_pkg::DIVISOR_W'(1);
                else if (ws45_reg < 0)
                    dv45_next = dse_pkg::DIVISOR_W'(-ws45_reg);
                else
                    dv45_next = dse_pkg::DIVISOR_W'(ws45_reg);
                if (ws135_reg == '0)
                    dv135_next = dse_pkg::DIVISOR_W'(1);
                else if (ws135_reg < 0)
                    dv135_next = dse_pkg::DIVISOR_W'(-ws135_reg);
                else
                    dv135_next = dse_pkg::DIVISOR_W'(ws135_reg);
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (t45 >= {1'b0, dv45_reg})
                begin
                    rm45_next = dse_pkg::DIVISOR_W'(t45 - {1'b0, dv45_reg});
                    dq45_next = {dq45_reg[dse_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rm45_next = t45[dse_pkg::DIVISOR_W-1:0];
                    dq45_next = {dq45_reg[dse_pkg::DIV_W-2:0], 1'b0};
                end
                if (t135 >= {1'b0, dv135_reg})
                begin
                    rm135_next = dse_pkg::DIVISOR_W'(t135 - {1'b0, dv135_reg});
                    dq135_next = {dq135_reg[dse_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rm135_next = t135[dse_pkg::DIVISOR_W-1:0];
                    dq135_next = {dq135_reg[dse_pkg::DIV_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == dse_pkg::DIV_STEPS - 4'd1)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    dst_valid_next = 1'b1;
                    dst_data_next.edge_value = (half > dse_pkg::DIV_W'(255))
                                             ? 8'd255 : half[7:0];
                    dst_data_next.frame_last = is_last;
                    if (is_last)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                        lead_next    = '0;
                    end
                    else
                    begin
                        lead_next = lead_reg - LW'(1);
                        if (((WW + 1)'(out_col_reg) + (WW + 1)'(1)) >= (WW + 1)'(eff_w))
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + dse_pkg::OUT_ROW_W'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + CW'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= dse_pkg::FRAME_WIDTH_RESET;
            fh_reg        <= dse_pkg::FRAME_HEIGHT_RESET;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            lead_reg      <= '0;
            tap_valid_reg <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            lead_reg      <= lead_next;
            tap_valid_reg <= tap_valid_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ty_reg       <= ty_next;
        tx_reg       <= tx_next;
        tap_in_reg   <= tap_in_next;
        w45_reg      <= w45_next;
        w135_reg     <= w135_next;
        acc45_reg    <= acc45_next;
        acc135_reg   <= acc135_next;
        ws45_reg     <= ws45_next;
        ws135_reg    <= ws135_next;
        dq45_reg     <= dq45_next;
        dq135_reg    <= dq135_next;
        rm45_reg     <= rm45_next;
        rm135_reg    <= rm135_next;
        dv45_reg     <= dv45_next;
        dv135_reg    <= dv135_next;
        div_cnt_reg  <= div_cnt_next;
        dst_data_reg <= dst_data_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

@@ design/dse_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ verif/diagonal_sobel_edge_filter_checker.sv @@
// Checker for the diagonal Sobel edge filter: predicts each result from the
// observed configuration writes and input transfers and compares the output.
// Depends on dse_pkg.
`timescale 1ns / 100ps

module diagonal_sobel_edge_filter_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [dse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           src_valid,
    input  logic                           src_stall,
    input  dse_pkg::src_item_t             src_data,
    input  logic                           dst_valid,
    input  logic                           dst_stall,
    input  dse_pkg::dst_item_t             dst_data,
    output int                             mismatches,
    output int                             owed
);

    localparam int ROW_SPAN = 1024;

    // Weight at offset (dy,dx) is taken from [dx+1][dy+1].
    localparam int DIAG45 [3][3]  = '{'{0, 1, 2}, '{1, 0, -1}, '{-2, -1, 0}};
    localparam int DIAG135 [3][3] = '{'{2, 1, 0}, '{-1, 0, 1}, '{0, -1, -2}};

    logic [7:0]          rows_mem [0:4*ROW_SPAN-1];
    int unsigned         width_reg, height_reg;
    int unsigned         in_x, in_y, out_x, out_y;
    dse_pkg::dst_item_t  edge_queue [$];
    int                  fails;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int diag_sum(bit use135, int y, int x, int w, int h);
        int sum;
        int wsum;
        int yy;
        int xx;
        int wt;
        sum = 0;
        wsum = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
            begin
                yy = y + dy;
                xx = x + dx;
                if (yy >= 0 && yy < h && xx >= 0 && xx < w)
                begin
                    wt = use135 ? DIAG135[dx+1][dy+1] : DIAG45[dx+1][dy+1];
                    sum += int'(rows_mem[(yy % 4) * ROW_SPAN + xx]) * wt;
                    wsum += wt;
                end
            end
        if (wsum != 0)
            return sum / wsum;
        return sum;
    endfunction

    // Advances the prediction by one accepted input transfer.
    task automatic take_item(dse_pkg::src_item_t item);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned outi;
        int a;
        int b;
        int m;
        bit ready;
        dse_pkg::dst_item_t res;
        w = clamp_size(width_reg, ROW_SPAN);
        h = clamp_size(height_reg, dse_pkg::MAX_HEIGHT);
        total = w * h;
        outi = out_y * w + out_x;
        if (item.op == dse_pkg::OP_PIXEL && in_y < h)
        begin
            rows_mem[(in_y % 4) * ROW_SPAN + in_x] = item.pixel;
            in_x++;
            if (in_x >= w)
            begin
                in_x = 0;
                in_y++;
            end
            ready = (in_y * w + in_x >= outi + w + 2) && (outi < total);
        end
        else
            ready = (in_y >= h) && (outi < total);
        if (ready)
        begin
            a = diag_sum(1'b0, out_y, out_x, w, h);
            b = diag_sum(1'b1, out_y, out_x, w, h);
            if (a < 0) a = -a;
            if (b < 0) b = -b;
            m = (a + b) / 2;
            if (m > 255) m = 255;
            res.edge_value = m[7:0];
            res.frame_last = (outi + 1 == total);
            edge_queue.push_back(res);
            if (res.frame_last)
            begin
                in_x = 0; in_y = 0; out_x = 0; out_y = 0;
            end
            else
            begin
                out_x++;
                if (out_x >= w)
                begin
                    out_x = 0;
                    out_y++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dse_pkg::dst_item_t want;
        if (!rst_n)
        begin
            width_reg = 640;
            height_reg = 480;
            in_x = 0; in_y = 0; out_x = 0; out_y = 0;
            edge_queue.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == dse_pkg::CFG_FRAME_WIDTH)
                    width_reg = cfg_data & 13'h7FF;
                else
                    height_reg = cfg_data;
                in_x = 0; in_y = 0; out_x = 0; out_y = 0;
            end
            if (src_valid && !src_stall)
                take_item(src_data);
            if (dst_valid && !dst_stall)
            begin
                if (edge_queue.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result: expected none, actual %0d/%0b",
                             $time, dst_data.edge_value, dst_data.frame_last);
                end
                else
                begin
                    want = edge_queue.pop_front();
                    if (dst_data.edge_value !== want.edge_value)
                    begin
                        fails++;
                        $display("%0t: edge_value: expected %0d, actual %0d",
                                 $time, want.edge_value, dst_data.edge_value);
                    end
                    if (dst_data.frame_last !== want.frame_last)
                    begin
                        fails++;
                        $display("%0t: frame_last: expected %0b, actual %0b",
                                 $time, want.frame_last, dst_data.frame_last);
                    end
                end
            end
        end
        mismatches <= fails;
        owed <= edge_queue.size();
    end

endmodule

@@ verif/diagonal_sobel_edge_filter_tb.sv @@
// Testbench top for the diagonal Sobel edge filter: clock, reset, stimulus and
// the final verdict. Depends on dse_pkg, the filter and its checker.
`timescale 1ns / 100ps

module diagonal_sobel_edge_filter_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 40;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic                           cfg_index;
    logic [dse_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           src_valid;
    logic                           src_stall;
    dse_pkg::src_item_t             src_data;
    logic                           dst_valid;
    logic                           dst_stall;
    dse_pkg::dst_item_t             dst_data;
    int                             mismatches;
    int                             owed;

    bit          quiet;
    bit          pressure_on;
    bit          pressure_done;
    int          hold_left;
    int          burst_left;
    int          cycles;
    int          sent;
    int unsigned eff_w;
    int unsigned eff_h;

    diagonal_sobel_edge_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    diagonal_sobel_edge_filter_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_data   (dst_data),
        .mismatches (mismatches),
        .owed       (owed)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            hold_left <= 0;
            burst_left <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            dst_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_on && !pressure_done)
        begin
            dst_stall <= 1'b1;
            hold_left <= 600;
            pressure_done <= 1'b1;
        end
        else if (burst_left != 0)
        begin
            dst_stall <= 1'b1;
            burst_left <= burst_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            dst_stall <= 1'b1;
            burst_left <= $urandom_range(0, 13);
        end
        else
            dst_stall <= 1'b0;
    end

    task automatic send_item(logic op, logic [7:0] pix);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data.op <= op;
        src_data.pixel <= pix;
        do @(posedge clk); while (src_stall);
        sent++;
    endtask

    // Waits until every predicted result has been taken, then lets the block settle.
    task automatic settle();
        src_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // One write cycle, with cfg_write low again before the task returns, so that writes never overlap.
    task automatic write_reg(logic idx, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[dse_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == dse_pkg::CFG_FRAME_WIDTH)
            eff_w = (value & 'h7FF) < 1 ? 1 : ((value & 'h7FF) > 1024 ? 1024 : value & 'h7FF);
        else
            eff_h = (value & 'h1FFF) < 1 ? 1 : ((value & 'h1FFF) > 4096 ? 4096 : value & 'h1FFF);
    endtask

    function automatic logic [7:0] pick_pixel();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends npix pixels of a frame, with stray flush items mixed in when noisy; a complete
    // frame is then drained with a mix of flush items and pixels, which act as flushes while results are pending.
    task automatic run_frame(int unsigned npix, bit noisy);
        int unsigned left;
        for (int unsigned i = 0; i < npix; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(dse_pkg::OP_FLUSH, pick_pixel());
            send_item(dse_pkg::OP_PIXEL, pick_pixel());
        end
        if (npix == eff_w * eff_h)
        begin
            left = eff_w + 1 < npix ? eff_w + 1 : npix;
            repeat (left)
                send_item($urandom_range(0, 2) == 0 ? dse_pkg::OP_PIXEL
                                                    : dse_pkg::OP_FLUSH, pick_pixel());
        end
        settle();
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = dse_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        src_valid = 1'b0;
        src_data = '0;
        quiet = 1'b0;
        pressure_on = 1'b0;
        cycles = 0;
        sent = 0;
        eff_w = 640;
        eff_h = 480;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A flush before any frame is complete gives nothing.
        send_item(dse_pkg::OP_FLUSH, 8'hA5);
        settle();
        write_reg(dse_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(dse_pkg::CFG_FRAME_HEIGHT, 1);
        run_frame(1, 1'b0);
        write_reg(dse_pkg::CFG_FRAME_WIDTH, 3);
        write_reg(dse_pkg::CFG_FRAME_HEIGHT, 3);
        run_frame(9, 1'b0);
        // Zero sizes saturate up to one.
        write_reg(dse_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(dse_pkg::CFG_FRAME_HEIGHT, 0);
        run_frame(1, 1'b0);
        // Width bits above the register are dropped, leaving a two-pixel row.
        write_reg(dse_pkg::CFG_FRAME_WIDTH, 2050);
        write_reg(dse_pkg::CFG_FRAME_HEIGHT, 3);
        run_frame(eff_w * eff_h, 1'b0);
        // All-ones data saturates to the widest row and the tallest frame; the
        // frames are cut short by the next write.
        write_reg(dse_pkg::CFG_FRAME_WIDTH, 8191);
        write_reg(dse_pkg::CFG_FRAME_HEIGHT, 2);
        run_frame(40, 1'b0);
        write_reg(dse_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(dse_pkg::CFG_FRAME_HEIGHT, 8191);
        run_frame(40, 1'b0);

        while (sent < 1000)
        begin
            if (sent > 850)
                quiet = 1'b1;
            w = $urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            if (eff_w != w || $urandom_range(0, 1))
                write_reg(dse_pkg::CFG_FRAME_WIDTH, w);
            write_reg(dse_pkg::CFG_FRAME_HEIGHT, h);
            if (sent > 200 && !pressure_on)
                pressure_on = 1'b1;
            if ($urandom_range(0, 9) == 0)
                run_frame($urandom_range(0, eff_w * eff_h - 1), 1'b1);
            else
                run_frame(eff_w * eff_h, 1'b1);
        end
        settle();

        if (mismatches == 0 && owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
